[sv/fpba_pkg.sv]
`timescale 1ns / 1ps

package fpba_pkg;

  localparam int NUM_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int SLOT_W     = 4;
  localparam int POLICY_W   = 2;
  localparam int COUNT_W    = 5;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 1;

  // Fit policy codes.
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

  // Item modes.
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  typedef logic [SIZE_BITS-1:0] size_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef struct packed {
    logic  used;
    size_t size;
  } entry_t;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    entry_t wdata;
    idx_t   raddr;
  } mem_req_t;

endpackage

[sv/fpba_if.sv]
`timescale 1ns / 1ps

interface fpba_in_if;
  import fpba_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [SLOT_W-1:0] block_slot;
  size_t             size_value;

  modport source (output valid, mode, block_slot, size_value, input ready);
  modport sink (input valid, mode, block_slot, size_value, output ready);
endinterface

interface fpba_out_if;
  import fpba_pkg::*;
  logic valid;
  logic ready;
  logic granted;
  idx_t chosen_block;

  modport source (output valid, granted, chosen_block, input ready);
  modport sink (input valid, granted, chosen_block, output ready);
endinterface

[sv/fit_policy_block_allocator_core.sv]
`timescale 1ns / 1ps

// A load transaction is written in the cycle it is accepted. A request scans
// min(block_count, 16) blocks, one per cycle; ST_LAST then tests the last entry read and
// ST_FIN loads the result into the output register. A zero count or undefined policy goes
// straight to ST_FIN. Loads are taken every cycle while idle; a request closes the input
// until its result is loaded. A result held by the receiver stalls the next one.
// Reset (synchronous, rst_n low): policy first fit, block count 16, all blocks size zero
// and unused, no result pending.
module fit_policy_block_allocator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  fpba_in_if.sink                           in_ch,
  fpba_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fpba_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import fpba_pkg::*;

  // Configuration registers. They must only be written while the block is idle (the user's
  // rule; the block does not enforce it), so the controller reads them directly during a scan.
  logic [POLICY_W-1:0] fit_policy_r;
  logic [COUNT_W-1:0]  block_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r  <= POL_FIRST;
      block_count_r <= COUNT_W'(NUM_BLOCKS);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIT_POLICY:  fit_policy_r  <= cfg_wdata[POLICY_W-1:0];
        REG_BLOCK_COUNT: block_count_r <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // The block table holds each block's remaining size and its used mark in one
  // entry. The controller scans it one entry per cycle, keeps the best
  // candidate so far, and writes the chosen entry back when the result is
  // loaded into the output register.
  mem_req_t mem_req;
  entry_t   mem_rd;

  fpba_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (mem_rd)
  );

  fpba_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .fit_policy  (fit_policy_r),
    .block_count (block_count_r),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mem_req     (mem_req),
    .mem_rd      (mem_rd)
  );

`ifndef ASSERT_OFF
  // A request occupies the scan, so the input closes right after it.
  a_req_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.mode == MODE_REQUEST |=> !in_ch.ready)
    else $error("input still open after a request was accepted");

  // A load is finished in its own cycle and never stalls the input.
  a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.mode == MODE_LOAD |=> in_ch.ready)
    else $error("input closed after a load");

  // A refusal always reports block zero.
  a_refusal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.granted |-> out_ch.chosen_block == '0)
    else $error("refused request reports a nonzero block");

  // A granted block lies inside the searched range.
  a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.granted |->
      COUNT_W'(out_ch.chosen_block) < block_count_r)
    else $error("granted block outside the searched range");
`endif

endmodule

[sv/fpba_mem.sv]
`timescale 1ns / 1ps

module fpba_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  fpba_pkg::mem_req_t req,
  output fpba_pkg::entry_t   rd_data
);
  import fpba_pkg::*;

  entry_t                mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] vld_r;
  entry_t                rd_q_r;
  logic                  rd_vld_r;

  // An entry never loaded reads as size zero, unused.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_q_r <= mem[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.we) begin
        vld_r[req.waddr] <= 1'b1;
      end
      rd_vld_r <= vld_r[req.raddr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

[sv/fpba_ctrl.sv]
`timescale 1ns / 1ps

module fpba_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [fpba_pkg::POLICY_W-1:0]   fit_policy,
  input  logic [fpba_pkg::COUNT_W-1:0]    block_count,
  fpba_in_if.sink                         in_ch,
  fpba_out_if.source                      out_ch,
  output fpba_pkg::mem_req_t              mem_req,
  input  fpba_pkg::entry_t                mem_rd
);
  import fpba_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_LAST = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  cnt_t       cnt_r, cnt_nxt;
  cnt_t       lim_r, lim_nxt;
  logic       pend_r, pend_nxt;
  idx_t       pend_idx_r, pend_idx_nxt;
  size_t      req_r, req_nxt;
  logic       found_r, found_nxt;
  idx_t       pick_r, pick_nxt;
  size_t      best_sz_r, best_sz_nxt;
  logic       best_used_r, best_used_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_granted_r, out_granted_nxt;
  idx_t       out_block_r, out_block_nxt;

  logic       accept;
  logic       out_free;
  logic       take;
  logic       fits;
  logic       policy_ok;
  cnt_t       lim_in;

  assign accept    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign policy_ok = fit_policy inside {POL_FIRST, POL_BEST, POL_WORST};
  assign lim_in    = (block_count > COUNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                          : CNT_W'(block_count);

  // Candidate test on the entry returned by the memory this cycle.
  assign fits = (mem_rd.size >= req_r);
  always_comb begin
    take = 1'b0;
    case (fit_policy)
      POL_FIRST: take = fits && !found_r;
      POL_BEST:  take = fits && !mem_rd.used && (!found_r || mem_rd.size < best_sz_r);
      POL_WORST: take = fits && (!found_r || mem_rd.size > best_sz_r);
      default:   take = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    lim_nxt       = lim_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    req_nxt       = req_r;
    found_nxt     = found_r;
    pick_nxt      = pick_r;
    best_sz_nxt   = best_sz_r;
    best_used_nxt = best_used_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_granted_nxt = out_granted_r;
    out_block_nxt = out_block_r;
    mem_req       = '0;

    if (pend_r && take) begin
      found_nxt     = 1'b1;
      pick_nxt      = pend_idx_r;
      best_sz_nxt   = mem_rd.size;
      best_used_nxt = mem_rd.used;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.mode == MODE_LOAD) begin
            mem_req.we    = (int'(in_ch.block_slot) < NUM_BLOCKS);
            mem_req.waddr = IDX_W'(in_ch.block_slot);
            mem_req.wdata = '{used: 1'b0, size: in_ch.size_value};
          end else begin
            req_nxt   = in_ch.size_value;
            found_nxt = 1'b0;
            cnt_nxt   = '0;
            lim_nxt   = lim_in;
            if (lim_in == '0 || !policy_ok) begin
              state_nxt = ST_FIN;
            end else begin
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        mem_req.raddr = cnt_r[IDX_W-1:0];
        pend_nxt      = 1'b1;
        pend_idx_nxt  = cnt_r[IDX_W-1:0];
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == lim_r - 1'b1) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          mem_req.we    = found_r;
          mem_req.waddr = pick_r;
          if (fit_policy == POL_BEST) begin
            mem_req.wdata = '{used: 1'b1, size: best_sz_r};
          end else begin
            mem_req.wdata = '{used: best_used_r, size: best_sz_r - req_r};
          end
          out_valid_nxt   = 1'b1;
          out_granted_nxt = found_r;
          out_block_nxt   = found_r ? pick_r : '0;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r         <= cnt_nxt;
    lim_r         <= lim_nxt;
    pend_idx_r    <= pend_idx_nxt;
    req_r         <= req_nxt;
    pick_r        <= pick_nxt;
    best_sz_r     <= best_sz_nxt;
    best_used_r   <= best_used_nxt;
    out_granted_r <= out_granted_nxt;
    out_block_r   <= out_block_nxt;
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.granted      = out_granted_r;
  assign out_ch.chosen_block = out_block_r;

endmodule
